// ----- hw/rtl/equal_pair_sum_finder_assert.svh -----
// assertion macros shared by the equal pair sum finder rtl
// expects clk and rst_n in the scope of each use
`ifndef EQUAL_PAIR_SUM_FINDER_ASSERT_SVH
`define EQUAL_PAIR_SUM_FINDER_ASSERT_SVH

// condition that holds at every clock edge outside reset
`define EPSF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// implication checked in the same cycle
`define EPSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/epsf_pkg.sv -----
// types and fixed widths of the equal pair sum finder
// no dependencies
package epsf_pkg;

  localparam int VAL_W = 31;
  localparam int SUM_W = 32;

  typedef struct packed {
    logic head_rd;
    logic node_from_head;
    logic node_from_link;
    logic insert;
    logic linked;
  } epsf_tbl_cmd_t;

  typedef struct packed {
    logic busy;
    logic head_empty;
    logic bucket_ok;
    logic hit;
    logic has_link;
  } epsf_tbl_stat_t;

endpackage

// ----- hw/rtl/epsf_ifs.sv -----
// valid/ready channel interfaces for element input and result output
// depends on epsf_pkg
interface epsf_in_if;
  import epsf_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] element_value;
  logic             last_element;
  modport source (output valid, element_value, last_element, input ready);
  modport sink (input valid, element_value, last_element, output ready);
endinterface

interface epsf_out_if;
  import epsf_pkg::*;
  logic             valid;
  logic             ready;
  logic             pair_found;
  logic [VAL_W-1:0] first_a;
  logic [VAL_W-1:0] first_b;
  logic [VAL_W-1:0] second_c;
  logic [VAL_W-1:0] second_d;
  logic [SUM_W-1:0] common_sum;
  logic             overflow;
  modport source (output valid, pair_found, first_a, first_b, second_c, second_d,
                  common_sum, overflow, input ready);
  modport sink (input valid, pair_found, first_a, first_b, second_c, second_d,
                common_sum, overflow, output ready);
endinterface

// ----- hw/rtl/equal_pair_sum_finder.sv -----
// equal pair sum finder top level: sequencer, counters and result register
// depends on epsf_pkg, epsf_ifs, epsf_elem_store, epsf_sum_table
//
// usage
//   in_port carries one set element per word; last_element marks the final
//   word of a set and starts the search. out_port carries one result word per
//   set: two disjoint pairs of equal sum (earlier stored pair first) or
//   not-found with zero payload, plus the overflow flag for that set.
//   elements past MAX_ELEMS are dropped and raise overflow.
// timing
//   loading takes one word per cycle while in_ready is high. the search walks
//   pairs (i,j), i<j, in index order; each pair is read, summed, looked up
//   at its bucket head, compared along the chain one node at a time through
//   the single node memory read port, then inserted unless it hits. in_ready
//   is low during the search.
// reset
//   after reset the bucket heads are swept to zero; in_ready stays low until
//   the sweep ends. counters and the overflow flag clear after each result.
// stall
//   a result waits in the output register; the next set can load meanwhile,
//   and its search result is held back until the previous word is taken.
`include "equal_pair_sum_finder_assert.svh"

module equal_pair_sum_finder #(
  parameter int MAX_ELEMS = 16,
  parameter int BUCKETS   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  epsf_in_if.sink    in_port,
  epsf_out_if.source out_port
);
  import epsf_pkg::*;

  localparam int NODE_CAP = MAX_ELEMS * (MAX_ELEMS - 1) / 2;
  localparam int NCW      = $clog2(NODE_CAP + 1);
  localparam int CW       = $clog2(MAX_ELEMS + 1);
  localparam int EW       = $clog2(MAX_ELEMS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_HEAD  = 4'd4;
  localparam logic [3:0] S_HVAL  = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [NCW-1:0] node_cnt_r, node_cnt_nxt;
  logic [EW-1:0]  i_r, i_nxt;
  logic [EW-1:0]  j_r, j_nxt;
  logic           ovf_r, ovf_nxt;
  logic           first_r, first_nxt;
  logic           linked_r, linked_nxt;
  logic           found_r, found_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [VAL_W-1:0] c_r, d_r, a_r, b_r;
  logic [SUM_W-1:0] sum_r;
  logic             out_pair_found_r;
  logic [VAL_W-1:0] out_first_a_r, out_first_b_r, out_second_c_r, out_second_d_r;
  logic [SUM_W-1:0] out_common_sum_r;
  logic             out_overflow_r;

  logic             elem_wr, elem_rd, sum_ld, hit_ld, out_ld;
  logic [VAL_W-1:0] elem_c, elem_d, tbl_a, tbl_b;
  epsf_tbl_cmd_t    cmd;
  epsf_tbl_stat_t   stat;

  epsf_elem_store #(.MAX_ELEMS(MAX_ELEMS)) u_elem_store (
    .clk       (clk),
    .wr_en     (elem_wr),
    .wr_addr   (cnt_r[EW-1:0]),
    .wr_data   (in_port.element_value),
    .rd_en     (elem_rd),
    .rd_addr_c (i_r),
    .rd_addr_d (j_r),
    .rd_c      (elem_c),
    .rd_d      (elem_d)
  );

  epsf_sum_table #(.MAX_ELEMS(MAX_ELEMS), .BUCKETS(BUCKETS)) u_sum_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sum_i    (sum_r),
    .val_c    (c_r),
    .val_d    (d_r),
    .node_cnt (node_cnt_r),
    .stat     (stat),
    .hit_a    (tbl_a),
    .hit_b    (tbl_b)
  );

  assign in_port.ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    node_cnt_nxt  = node_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ovf_nxt       = ovf_r;
    first_nxt     = first_r;
    linked_nxt    = linked_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    elem_wr       = 1'b0;
    elem_rd       = 1'b0;
    sum_ld        = 1'b0;
    hit_ld        = 1'b0;
    out_ld        = 1'b0;
    cmd           = '0;

    if (out_valid_r && out_port.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        if (!stat.busy) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (in_port.valid) begin
          if (cnt_r < CW'(MAX_ELEMS)) begin
            elem_wr = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_port.last_element) begin
            i_nxt     = '0;
            j_nxt     = EW'(1);
            found_nxt = 1'b0;
            state_nxt = (cnt_nxt < CW'(2)) ? S_DONE : S_RD;
          end
        end
      end
      S_RD: begin
        elem_rd   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_ld    = 1'b1;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HVAL;
      end
      S_HVAL: begin
        if (stat.head_empty) begin
          linked_nxt = 1'b0;
          state_nxt  = S_INS;
        end else begin
          cmd.node_from_head = 1'b1;
          first_nxt          = 1'b1;
          state_nxt          = S_WALK;
        end
      end
      S_WALK: begin
        priority if (first_r && !stat.bucket_ok) begin
          // stale head from an earlier set
          linked_nxt = 1'b0;
          state_nxt  = S_INS;
        end else if (stat.hit) begin
          found_nxt = 1'b1;
          hit_ld    = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.has_link) begin
          cmd.node_from_link = 1'b1;
          first_nxt          = 1'b0;
        end else begin
          linked_nxt = 1'b1;
          state_nxt  = S_INS;
        end
      end
      S_INS: begin
        cmd.insert   = 1'b1;
        cmd.linked   = linked_r;
        node_cnt_nxt = node_cnt_r + 1'b1;
        priority if (CW'(j_r) + CW'(1) < cnt_r) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RD;
        end else if (CW'(i_r) + CW'(2) < cnt_r) begin
          i_nxt     = i_r + EW'(1);
          j_nxt     = i_r + EW'(2);
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_port.ready) begin
          out_ld        = 1'b1;
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          node_cnt_nxt  = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      node_cnt_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      ovf_r       <= 1'b0;
      first_r     <= 1'b0;
      linked_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      node_cnt_r  <= node_cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      ovf_r       <= ovf_nxt;
      first_r     <= first_nxt;
      linked_r    <= linked_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ld) begin
      c_r   <= elem_c;
      d_r   <= elem_d;
      sum_r <= SUM_W'(elem_c) + SUM_W'(elem_d);
    end
    if (hit_ld) begin
      a_r <= tbl_a;
      b_r <= tbl_b;
    end
    if (out_ld) begin
      out_pair_found_r <= found_r;
      out_first_a_r    <= found_r ? a_r : '0;
      out_first_b_r    <= found_r ? b_r : '0;
      out_second_c_r   <= found_r ? c_r : '0;
      out_second_d_r   <= found_r ? d_r : '0;
      out_common_sum_r <= found_r ? sum_r : '0;
      out_overflow_r   <= ovf_r;
    end
  end

  assign out_port.valid      = out_valid_r;
  assign out_port.pair_found = out_pair_found_r;
  assign out_port.first_a    = out_first_a_r;
  assign out_port.first_b    = out_first_b_r;
  assign out_port.second_c   = out_second_c_r;
  assign out_port.second_d   = out_second_d_r;
  assign out_port.common_sum = out_common_sum_r;
  assign out_port.overflow   = out_overflow_r;

  `EPSF_ASSERT(a_cnt_max, cnt_r <= CW'(MAX_ELEMS), "element count beyond capacity")
  `EPSF_ASSERT(a_node_cap, node_cnt_r <= NCW'(NODE_CAP), "node count beyond pair count")
  `EPSF_ASSERT_IMPL(a_pair_order, state_r == S_RD, i_r < j_r, "pair indices out of order")
  `EPSF_ASSERT_IMPL(a_not_found_zero, out_valid_r && !out_pair_found_r,
    out_common_sum_r == '0, "not-found word with non-zero sum")
  `EPSF_ASSERT_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE,
    "result word raised outside done")

endmodule

// ----- hw/rtl/epsf_elem_store.sv -----
// element memory: one write port, two registered read ports
// depends on epsf_pkg
module epsf_elem_store #(
  parameter int MAX_ELEMS = 16
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_ELEMS)-1:0]  wr_addr,
  input  logic [epsf_pkg::VAL_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_ELEMS)-1:0]  rd_addr_c,
  input  logic [$clog2(MAX_ELEMS)-1:0]  rd_addr_d,
  output logic [epsf_pkg::VAL_W-1:0]    rd_c,
  output logic [epsf_pkg::VAL_W-1:0]    rd_d
);
  import epsf_pkg::*;

  logic [VAL_W-1:0] mem [MAX_ELEMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_c <= mem[rd_addr_c];
      rd_d <= mem[rd_addr_d];
    end
  end

endmodule

// ----- hw/rtl/epsf_sum_table.sv -----
// chained hash table of pair sums: bucket heads, node memory, match compare
// depends on epsf_pkg; heads are swept to zero after reset
module epsf_sum_table #(
  parameter int MAX_ELEMS = 16,
  parameter int BUCKETS   = 64
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  epsf_pkg::epsf_tbl_cmd_t                              cmd,
  input  logic [epsf_pkg::SUM_W-1:0]                           sum_i,
  input  logic [epsf_pkg::VAL_W-1:0]                           val_c,
  input  logic [epsf_pkg::VAL_W-1:0]                           val_d,
  input  logic [$clog2(MAX_ELEMS*(MAX_ELEMS-1)/2+1)-1:0]       node_cnt,
  output epsf_pkg::epsf_tbl_stat_t                             stat,
  output logic [epsf_pkg::VAL_W-1:0]                           hit_a,
  output logic [epsf_pkg::VAL_W-1:0]                           hit_b
);
  import epsf_pkg::*;

  localparam int NODE_CAP = MAX_ELEMS * (MAX_ELEMS - 1) / 2;
  localparam int NIW      = $clog2(NODE_CAP);
  localparam int NCW      = $clog2(NODE_CAP + 1);
  localparam int BW       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  typedef struct packed {
    logic [BW-1:0]    bkt;
    logic             lvld;
    logic [NIW-1:0]   link;
    logic [VAL_W-1:0] va;
    logic [VAL_W-1:0] vb;
    logic [SUM_W-1:0] sum;
  } node_t;

  logic [NIW-1:0] head_mem [BUCKETS];
  node_t          node_mem [NODE_CAP];

  logic [NIW-1:0] head_q;
  node_t          node_q;
  node_t          node_wr;
  logic [NIW-1:0] node_rd_addr;
  logic [BW-1:0]  low_bits;
  logic [BW-1:0]  bucket;
  logic [BW-1:0]  clr_idx_r;
  logic [BW-1:0]  clr_idx_nxt;
  logic           clr_busy_r;
  logic           clr_busy_nxt;

  // bucket from the low sum bits, folded once into range
  assign low_bits = sum_i[BW-1:0];
  assign bucket   = (low_bits >= BW'(BUCKETS)) ? (low_bits - BW'(BUCKETS)) : low_bits;

  assign node_rd_addr = cmd.node_from_link ? node_q.link : head_q;

  always_comb begin
    node_wr.bkt  = bucket;
    node_wr.lvld = cmd.linked;
    node_wr.link = head_q;
    node_wr.va   = val_c;
    node_wr.vb   = val_d;
    node_wr.sum  = sum_i;
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      if (clr_idx_r == BW'(BUCKETS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      head_mem[clr_idx_r] <= '0;
    end else if (cmd.insert) begin
      head_mem[bucket] <= node_cnt[NIW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      head_q <= head_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      node_mem[node_cnt[NIW-1:0]] <= node_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_from_head || cmd.node_from_link) begin
      node_q <= node_mem[node_rd_addr];
    end
  end

  // a head is live only if it points below the fill count at a node of its bucket
  always_comb begin
    stat.busy       = clr_busy_r;
    stat.head_empty = NCW'(head_q) >= node_cnt;
    stat.bucket_ok  = node_q.bkt == bucket;
    stat.hit        = (node_q.sum == sum_i) &&
                      (node_q.va != val_c) && (node_q.va != val_d) &&
                      (node_q.vb != val_c) && (node_q.vb != val_d);
    stat.has_link   = node_q.lvld;
  end

  assign hit_a = node_q.va;
  assign hit_b = node_q.vb;

endmodule

// ----- test/testbench.sv -----
// testbench for equal_pair_sum_finder: directed sets against fixed results, then
// random sets against a pair search predictor; depends on epsf_pkg, epsf_ifs, rtl
module testbench;
  import epsf_pkg::*;

  localparam int MAX_ELEMS    = 16;
  localparam int BUCKETS      = 64;
  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_LIMIT  = 60000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PRINT_CAP    = 40;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    logic             pair_found;
    logic [VAL_W-1:0] first_a;
    logic [VAL_W-1:0] first_b;
    logic [VAL_W-1:0] second_c;
    logic [VAL_W-1:0] second_d;
    logic [SUM_W-1:0] common_sum;
    logic             overflow;
  } finder_result_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    bit               last;
    bit               typed;
    finder_result_t   result;
  } stim_row_t;

  logic clk;
  logic rst_n;

  epsf_in_if  in_if();
  epsf_out_if out_if();

  equal_pair_sum_finder #(
    .MAX_ELEMS(MAX_ELEMS),
    .BUCKETS  (BUCKETS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_port (in_if),
    .out_port(out_if)
  );

  logic [VAL_W-1:0] set_vals[$];
  bit               set_overflow;
  finder_result_t   expected_results[$];
  finder_result_t   oldest_result;
  stim_row_t        directed_rows[$];
  int               mismatch_count;
  int               items_sent;
  int               src_idle_pct;
  int               snk_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic finder_result_t make_result(input logic found,
                                                 input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic [VAL_W-1:0] c,
                                                 input logic [VAL_W-1:0] d,
                                                 input logic [SUM_W-1:0] s,
                                                 input logic ovf);
    finder_result_t r;
    r.pair_found = found;
    r.first_a    = a;
    r.first_b    = b;
    r.second_c   = c;
    r.second_d   = d;
    r.common_sum = s;
    r.overflow   = ovf;
    return r;
  endfunction

  // loads one word into the set; on the marked word runs the pair search
  function automatic bit predict_element(input logic [VAL_W-1:0] v, input bit last,
                                         output finder_result_t res);
    logic [SUM_W-1:0] sums[$];
    logic [VAL_W-1:0] lo_vals[$];
    logic [VAL_W-1:0] hi_vals[$];
    logic [SUM_W-1:0] s;
    logic [VAL_W-1:0] c;
    logic [VAL_W-1:0] d;
    bit               hit;
    res = '0;
    if (set_vals.size() < MAX_ELEMS) begin
      set_vals.push_back(v);
    end else begin
      set_overflow = 1'b1;
    end
    if (!last) return 1'b0;
    hit = 1'b0;
    for (int i = 0; i < set_vals.size() && !hit; i++) begin
      for (int j = i + 1; j < set_vals.size() && !hit; j++) begin
        c = set_vals[i];
        d = set_vals[j];
        s = {1'b0, c} + {1'b0, d};
        // newest stored pair first
        for (int k = sums.size() - 1; k >= 0 && !hit; k--) begin
          if (sums[k] == s && lo_vals[k] != c && lo_vals[k] != d &&
              hi_vals[k] != c && hi_vals[k] != d) begin
            hit = 1'b1;
            res = make_result(1'b1, lo_vals[k], hi_vals[k], c, d, s, 1'b0);
          end
        end
        if (!hit) begin
          sums.push_back(s);
          lo_vals.push_back(c);
          hi_vals.push_back(d);
        end
      end
    end
    res.overflow = set_overflow;
    set_vals.delete();
    set_overflow = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_word(input logic [VAL_W-1:0] v, input bit last, input bit typed,
                           input finder_result_t typed_res);
    finder_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.element_value <= v;
    in_if.last_element  <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    if (predict_element(v, last, predicted)) begin
      expected_results.push_back(typed ? typed_res : predicted);
    end
  endtask

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_if.pair_found !== oldest_result.pair_found)
          report_mismatch($sformatf("pair_found %0b, expected %0b",
                                    out_if.pair_found, oldest_result.pair_found));
        if (out_if.first_a !== oldest_result.first_a)
          report_mismatch($sformatf("first_a %0h, expected %0h",
                                    out_if.first_a, oldest_result.first_a));
        if (out_if.first_b !== oldest_result.first_b)
          report_mismatch($sformatf("first_b %0h, expected %0h",
                                    out_if.first_b, oldest_result.first_b));
        if (out_if.second_c !== oldest_result.second_c)
          report_mismatch($sformatf("second_c %0h, expected %0h",
                                    out_if.second_c, oldest_result.second_c));
        if (out_if.second_d !== oldest_result.second_d)
          report_mismatch($sformatf("second_d %0h, expected %0h",
                                    out_if.second_d, oldest_result.second_d));
        if (out_if.common_sum !== oldest_result.common_sum)
          report_mismatch($sformatf("common_sum %0h, expected %0h",
                                    out_if.common_sum, oldest_result.common_sum));
        if (out_if.overflow !== oldest_result.overflow)
          report_mismatch($sformatf("overflow %0b, expected %0b",
                                    out_if.overflow, oldest_result.overflow));
      end
    end
  end

  // ends the run when no word moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t        row;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] base;
    int               set_len;
    int               mode;
    int               pick;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.element_value  = '0;
    in_if.last_element   = 1'b0;
    out_if.ready         = 1'b0;
    mismatch_count       = 0;
    items_sent           = 0;
    set_overflow         = 1'b0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;

    // fewer than four elements, field extremes
    directed_rows.push_back('{0, 1'b0, 1'b0, '0});
    directed_rows.push_back('{VAL_MAX, 1'b0, 1'b0, '0});
    directed_rows.push_back('{1, 1'b1, 1'b1, '0});
    // smallest set with a hit
    directed_rows.push_back('{1, 1'b0, 1'b0, '0});
    directed_rows.push_back('{2, 1'b0, 1'b0, '0});
    directed_rows.push_back('{3, 1'b0, 1'b0, '0});
    directed_rows.push_back('{4, 1'b1, 1'b1, make_result(1'b1, 1, 4, 2, 3, 5, 1'b0)});
    // hit at the top of the value range
    directed_rows.push_back('{VAL_MAX, 1'b0, 1'b0, '0});
    directed_rows.push_back('{VAL_MAX - 1'b1, 1'b0, 1'b0, '0});
    directed_rows.push_back('{VAL_MAX - 2'd2, 1'b0, 1'b0, '0});
    directed_rows.push_back('{VAL_MAX - 2'd3, 1'b1, 1'b1,
                              make_result(1'b1, VAL_MAX, VAL_MAX - 2'd3, VAL_MAX - 1'b1,
                                          VAL_MAX - 2'd2, 32'hFFFF_FFFB, 1'b0)});
    // repeated values past capacity, marked word dropped
    for (int k = 0; k < MAX_ELEMS + 1; k++) begin
      directed_rows.push_back('{9, k == MAX_ELEMS, k == MAX_ELEMS,
                                make_result(1'b0, 0, 0, 0, 0, 0, 1'b1)});
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      send_word(row.value, row.last, row.typed, row.result);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase
      while (items_sent < directed_rows.size() + (phase + 1) * RANDOM_ITEMS / 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          set_len = $urandom_range(1, 3);
        end else if (pick < 92) begin
          set_len = $urandom_range(4, 9);
        end else if (pick < 97) begin
          set_len = $urandom_range(10, MAX_ELEMS);
        end else begin
          set_len = $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 4);
        end
        mode = $urandom_range(0, 3);
        base = VAL_W'($urandom_range(0, 32'h7FFF_FF00));
        for (int k = 0; k < set_len; k++) begin
          case (mode)
            0: v = VAL_W'($urandom_range(0, 63));
            1: v = VAL_W'($urandom);
            2: v = VAL_W'(base + $urandom_range(0, 255));
            default: v = (k % 2) ? VAL_W'($urandom_range(0, 31))
                                 : VAL_MAX - VAL_W'($urandom_range(0, 31));
          endcase
          send_word(v, k == set_len - 1, 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
